### rtl/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types, codes and defaults of the pump cycle sequencer.
// ----------------------------------------------------------------------------
package pcs_pkg;

    // Default number of pump-on periods in a routine.
    localparam int NUM_CYCLES_DEF = 5;

    // Width of the cycle counter for a given number of cycles.
    function automatic int cnt_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    localparam int CNT_W_DEF = cnt_w(NUM_CYCLES_DEF);

    // Phase codes.
    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_ON   = 2'd1;
    localparam logic [1:0] PH_OFF  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    // Operator instruction codes.
    localparam logic [2:0] IN_START = 3'd0;
    localparam logic [2:0] IN_ON    = 3'd1;
    localparam logic [2:0] IN_STOP  = 3'd2;
    localparam logic [2:0] IN_WAIT  = 3'd3;
    localparam logic [2:0] IN_DONE  = 3'd4;

    // Operation codes of an input word.
    localparam logic OP_UPDATE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Record kinds.
    localparam logic KIND_ON  = 1'b0;
    localparam logic KIND_OFF = 1'b1;

    // Configuration register indexes.
    localparam int          CFG_IDX_W      = 2;
    localparam logic [1:0]  CFG_TARGET     = 2'd0;
    localparam logic [1:0]  CFG_BEFORE     = 2'd1;
    localparam logic [1:0]  CFG_AFTER      = 2'd2;

    localparam logic [15:0] TARGET_RST = 16'd10000;
    localparam logic [15:0] BEFORE_RST = 16'd3000;
    localparam logic [15:0] AFTER_RST  = 16'd500;

    typedef struct packed {
        logic [15:0] target;
        logic [15:0] win_before;
        logic [15:0] after;
    } t_cfg;

    typedef struct packed {
        logic        operation;
        logic [31:0] now_ms;
        logic        pump_on;
    } t_in;

    // Sequencer state, apart from the cycle counter whose width follows NUM_CYCLES.
    typedef struct packed {
        logic [1:0]  phase;
        logic [31:0] phase_start;
        logic        pending;
        logic [31:0] change_start;
    } t_state;

    typedef struct packed {
        logic        phase_changed;
        logic [1:0]  phase;
        logic [2:0]  instruction;
        logic [1:0]  display_phase;
        logic [2:0]  display_instruction;
        logic [31:0] elapsed_ms;
        logic [15:0] remaining_ms;
        logic [31:0] display_elapsed_ms;
        logic        recorded_valid;
        logic        recorded_kind;
        logic [31:0] recorded_ms;
    } t_result;

endpackage

### rtl/pcs_in_if.sv
// ----------------------------------------------------------------------------
// pcs_in_if
// Input channel: one timed update or restart word per handshake.
// ----------------------------------------------------------------------------
interface pcs_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] now_ms;
    logic        pump_on;

    modport source (output valid, output operation, output now_ms, output pump_on,
                    input ready);
    modport sink   (input valid, input operation, input now_ms, input pump_on,
                    output ready);
endinterface

### rtl/pcs_out_if.sv
// ----------------------------------------------------------------------------
// pcs_out_if
// Result channel: one status word per input word.
// ----------------------------------------------------------------------------
interface pcs_out_if #(
    parameter int CNT_W = pcs_pkg::CNT_W_DEF
);
    logic             valid;
    logic             ready;
    logic             phase_changed;
    logic [1:0]       phase;
    logic [2:0]       instruction;
    logic [1:0]       display_phase;
    logic [2:0]       display_instruction;
    logic [31:0]      elapsed_ms;
    logic [15:0]      remaining_ms;
    logic [31:0]      display_elapsed_ms;
    logic [CNT_W-1:0] cycle_number;
    logic             recorded_valid;
    logic             recorded_kind;
    logic [31:0]      recorded_ms;

    modport source (output valid, output phase_changed, output phase, output instruction,
                    output display_phase, output display_instruction, output elapsed_ms,
                    output remaining_ms, output display_elapsed_ms, output cycle_number,
                    output recorded_valid, output recorded_kind, output recorded_ms,
                    input ready);
    modport sink   (input valid, input phase_changed, input phase, input instruction,
                    input display_phase, input display_instruction, input elapsed_ms,
                    input remaining_ms, input display_elapsed_ms, input cycle_number,
                    input recorded_valid, input recorded_kind, input recorded_ms,
                    output ready);
endinterface

### rtl/pcs_cfg_if.sv
// ----------------------------------------------------------------------------
// pcs_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pcs_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/pcs_cfg_regs.sv
// ----------------------------------------------------------------------------
// pcs_cfg_regs
// Configuration registers: target period and the two confirmation windows.
// ----------------------------------------------------------------------------
module pcs_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic [pcs_pkg::CFG_IDX_W-1:0]     i_wr_index,
    input  logic [15:0]                       i_wr_data,
    output pcs_pkg::t_cfg                     o_cfg
);
    import pcs_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_wr_index)
                CFG_TARGET: n_cfg.target     = i_wr_data;
                CFG_BEFORE: n_cfg.win_before = i_wr_data;
                CFG_AFTER:  n_cfg.after      = i_wr_data;
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target     <= TARGET_RST;
            r_cfg.win_before <= BEFORE_RST;
            r_cfg.after      <= AFTER_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

### rtl/pcs_step.sv
// ----------------------------------------------------------------------------
// pcs_step
// Next-state and result logic for one input word.
// ----------------------------------------------------------------------------
module pcs_step #(
    parameter int NUM_CYCLES = pcs_pkg::NUM_CYCLES_DEF,
    parameter int CNT_W      = pcs_pkg::cnt_w(NUM_CYCLES)
) (
    input  pcs_pkg::t_cfg       i_cfg,
    input  pcs_pkg::t_in        i_in,
    input  pcs_pkg::t_state     i_state,
    input  logic [CNT_W-1:0]    i_cnt,
    output pcs_pkg::t_state     o_state,
    output logic [CNT_W-1:0]    o_cnt,
    output pcs_pkg::t_result    o_res
);
    import pcs_pkg::*;

    localparam logic [CNT_W-1:0] LastCnt = CNT_W'(NUM_CYCLES - 1);

    logic [31:0] now;
    logic [31:0] d_ps;
    logic [31:0] d_cs;
    logic [31:0] d_csps;
    logic [31:0] seen;
    logic [31:0] since_chg;
    logic [31:0] cs_eff;
    logic [31:0] e_new;
    logic [31:0] elapsed;
    logic [15:0] win;
    logic        watch;
    logic        confirm;
    logic        is_last;
    logic        n_is_last;
    logic        changed;
    logic        rec;
    logic        rec_kind;
    logic [31:0] rec_ms;
    logic [2:0]  instr;
    logic [1:0]  sp;
    logic [2:0]  sinstr;
    t_state      nxt;
    logic [CNT_W-1:0] n_cnt;

    assign now    = i_in.now_ms;
    assign d_ps   = now - i_state.phase_start;
    assign d_cs   = now - i_state.change_start;
    assign d_csps = i_state.change_start - i_state.phase_start;

    // A change is first seen now unless one is already pending.
    assign cs_eff    = i_state.pending ? i_state.change_start : now;
    assign seen      = i_state.pending ? d_csps : d_ps;
    assign since_chg = i_state.pending ? d_cs : 32'd0;
    assign win       = (seen >= {16'd0, i_cfg.target}) ? i_cfg.after : i_cfg.win_before;
    assign confirm   = since_chg >= {16'd0, win};
    assign watch     = ((i_state.phase == PH_ON) && !i_in.pump_on) ||
                       ((i_state.phase == PH_OFF) && i_in.pump_on);
    assign is_last   = i_cnt >= LastCnt;

    always_comb begin
        nxt      = i_state;
        n_cnt    = i_cnt;
        changed  = 1'b0;
        rec      = 1'b0;
        rec_kind = KIND_ON;
        rec_ms   = 32'd0;
        e_new    = d_ps;
        if (i_in.operation == OP_RESTART) begin
            nxt.phase        = PH_WAIT;
            nxt.phase_start  = 32'd0;
            nxt.pending      = 1'b0;
            nxt.change_start = 32'd0;
            n_cnt            = '0;
        end else begin
            unique case (i_state.phase)
                PH_WAIT: begin
                    if (i_in.pump_on) begin
                        nxt.phase        = PH_ON;
                        nxt.phase_start  = now;
                        nxt.pending      = 1'b0;
                        nxt.change_start = 32'd0;
                        changed          = 1'b1;
                        e_new            = 32'd0;
                    end
                end
                PH_ON, PH_OFF: begin
                    if (!watch) begin
                        nxt.pending      = 1'b0;
                        nxt.change_start = 32'd0;
                    end else if (!confirm) begin
                        nxt.pending      = 1'b1;
                        nxt.change_start = cs_eff;
                    end else begin
                        // The period ends where the change was first seen.
                        rec              = 1'b1;
                        rec_kind         = (i_state.phase == PH_OFF) ? KIND_OFF : KIND_ON;
                        rec_ms           = seen;
                        changed          = 1'b1;
                        nxt.phase_start  = cs_eff;
                        nxt.pending      = 1'b0;
                        nxt.change_start = 32'd0;
                        e_new            = since_chg;
                        if (i_state.phase == PH_OFF) begin
                            nxt.phase = PH_ON;
                            n_cnt     = i_cnt + CNT_W'(1);
                        end else begin
                            nxt.phase = is_last ? PH_DONE : PH_OFF;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign elapsed   = ((nxt.phase == PH_ON) || (nxt.phase == PH_OFF)) ? e_new : 32'd0;
    assign n_is_last = n_cnt >= LastCnt;

    always_comb begin
        unique case (nxt.phase)
            PH_WAIT: instr = IN_START;
            PH_ON:   instr = (elapsed >= {16'd0, i_cfg.target}) ? IN_STOP : IN_ON;
            PH_OFF:  instr = (elapsed >= {16'd0, i_cfg.target}) ? IN_START : IN_WAIT;
            default: instr = IN_DONE;
        endcase
    end

    always_comb begin
        sp = nxt.phase;
        if (nxt.pending) begin
            if (nxt.phase == PH_ON) begin
                sp = n_is_last ? PH_ON : PH_OFF;
            end else if (nxt.phase == PH_OFF) begin
                sp = PH_ON;
            end
        end
    end

    always_comb begin
        priority if (!nxt.pending) begin
            sinstr = instr;
        end else if ((nxt.phase == PH_ON) && n_is_last) begin
            sinstr = IN_STOP;
        end else if (sp == PH_ON) begin
            sinstr = IN_ON;
        end else if (sp == PH_OFF) begin
            sinstr = IN_WAIT;
        end else begin
            sinstr = instr;
        end
    end

    always_comb begin
        o_res.phase_changed       = changed;
        o_res.phase               = nxt.phase;
        o_res.instruction         = instr;
        o_res.display_phase       = sp;
        o_res.display_instruction = sinstr;
        o_res.elapsed_ms          = elapsed;
        o_res.remaining_ms        = (elapsed >= {16'd0, i_cfg.target}) ? 16'd0 :
                                    i_cfg.target - elapsed[15:0];
        // The display differs from the phase only while a change is pending.
        o_res.display_elapsed_ms  = (sp != nxt.phase) ? since_chg : elapsed;
        o_res.recorded_valid      = rec;
        o_res.recorded_kind       = rec_kind;
        o_res.recorded_ms         = rec_ms;
    end

    assign o_state = nxt;
    assign o_cnt   = n_cnt;
endmodule

### rtl/pump_cycle_sequencer.sv
// A word accepted into the input register has its result valid once the step
// logic has written it into the result register; a stalled output delays that.
// Throughput: one word per cycle unless the output stalls; the update is one pass
// from input register via step logic to result register, which also writes state.
// Reset (i_rst_n low, synchronous) returns the phase to waiting, clears the
// cycle count and loads the default target period and confirmation windows.
// ----------------------------------------------------------------------------
// pump_cycle_sequencer
// Times a fixed number of pump-on and pump-off periods and reports status.
// ----------------------------------------------------------------------------
module pump_cycle_sequencer #(
    parameter int NUM_CYCLES = pcs_pkg::NUM_CYCLES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcs_in_if.sink     i_in,
    pcs_out_if.source  o_res,
    pcs_cfg_if.sink    i_cfg
);
    import pcs_pkg::*;

    localparam int CNT_W = cnt_w(NUM_CYCLES);

    t_cfg             cfg;
    t_in              r_in;
    logic             r_in_valid;
    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    t_result          r_res;
    t_result          n_res;
    logic             r_out_valid;
    logic             advance;
    logic             fire;
    logic             in_take;

    assign i_cfg.ready = 1'b1;

    pcs_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg)
    );

    assign advance    = !r_out_valid || o_res.ready;
    assign fire       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;
    assign in_take    = i_in.valid && i_in.ready;

    pcs_step #(
        .NUM_CYCLES (NUM_CYCLES),
        .CNT_W      (CNT_W)
    ) u_step (
        .i_cfg   (cfg),
        .i_in    (r_in),
        .i_state (r_state),
        .i_cnt   (r_cnt),
        .o_state (n_state),
        .o_cnt   (n_cnt),
        .o_res   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid           <= 1'b0;
            r_out_valid          <= 1'b0;
            r_state.phase        <= PH_WAIT;
            r_state.phase_start  <= 32'd0;
            r_state.pending      <= 1'b0;
            r_state.change_start <= 32'd0;
            r_cnt                <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
                r_cnt       <= n_cnt;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.operation <= i_in.operation;
            r_in.now_ms    <= i_in.now_ms;
            r_in.pump_on   <= i_in.pump_on;
        end
        if (fire) begin
            r_res <= n_res;
        end
    end

    // The cycle number is the state left by the word that the result belongs to.
    assign o_res.valid               = r_out_valid;
    assign o_res.phase_changed       = r_res.phase_changed;
    assign o_res.phase               = r_res.phase;
    assign o_res.instruction         = r_res.instruction;
    assign o_res.display_phase       = r_res.display_phase;
    assign o_res.display_instruction = r_res.display_instruction;
    assign o_res.elapsed_ms          = r_res.elapsed_ms;
    assign o_res.remaining_ms        = r_res.remaining_ms;
    assign o_res.display_elapsed_ms  = r_res.display_elapsed_ms;
    assign o_res.cycle_number        = r_cnt;
    assign o_res.recorded_valid      = r_res.recorded_valid;
    assign o_res.recorded_kind       = r_res.recorded_kind;
    assign o_res.recorded_ms         = r_res.recorded_ms;

`ifndef ASSERT_OFF
    a_rec_changes_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.recorded_valid) |-> r_res.phase_changed)
        else $error("period recorded without a phase change");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(NUM_CYCLES - 1))
        else $error("cycle count beyond the last cycle");

    a_pending_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pending |-> (r_state.phase == PH_ON || r_state.phase == PH_OFF))
        else $error("change pending outside the pump-on and pump-off phases");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in.operation == OP_RESTART) |=>
            (r_state.phase == PH_WAIT && !r_state.pending && r_cnt == '0))
        else $error("restart did not return to the waiting state");
`endif
endmodule
